>>> sv/mbsep_pkg.sv
// mbsep_pkg: shared types and constants for the midi byte stream event parser
// used by mbsep_decode and midi_byte_stream_event_parser_core; no dependencies
package mbsep_pkg;

  localparam logic [3:0] CMD_NONE       = 4'h0;
  localparam logic [3:0] CMD_NOTE_OFF   = 4'h8;
  localparam logic [3:0] CMD_NOTE_ON    = 4'h9;
  localparam logic [3:0] CMD_POLY_AT    = 4'hA;
  localparam logic [3:0] CMD_CONTROL    = 4'hB;
  localparam logic [3:0] CMD_PROGRAM    = 4'hC;
  localparam logic [3:0] CMD_CHAN_PRESS = 4'hD;
  localparam logic [3:0] CMD_BEND       = 4'hE;

  localparam logic [7:0] BYTE_REALTIME_MIN = 8'hF8;
  localparam logic [7:0] BYTE_SYSTEM_MIN   = 8'hF0;
  localparam logic [7:0] BYTE_SWALLOW_MAX  = 8'hF3;

  localparam logic [1:0] EVT_NOTE_ON  = 2'b00;
  localparam logic [1:0] EVT_NOTE_OFF = 2'b01;
  localparam logic [1:0] EVT_CONTROL  = 2'b10;

  typedef struct packed {
    logic       swallow;
    logic [3:0] cmd;
    logic       held;
    logic [6:0] first;
  } parse_state_t;

  typedef struct packed {
    logic       emit;
    logic [8:0] number;
    logic [6:0] level;
  } parse_result_t;

endpackage

>>> sv/midi_byte_stream_event_parser_core.sv
// midi_byte_stream_event_parser_core: top level of the midi running status parser
// depends on mbsep_pkg and mbsep_decode
//
// Takes one midi word per cycle while the result side is ready and delivers note
// on, note off and controller events. Each word goes into an input register, is
// parsed against the running status state and lands in the result register, so a
// word is accepted every cycle when the result side is ready, and an event passes
// through both registers after its last data word. Realtime, system and silent
// channel words pass through without a result.
module midi_byte_stream_event_parser_core (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_midi_byte,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [8:0] out_event_number,
  output logic [6:0] out_event_level
);
  import mbsep_pkg::*;

  logic                in_valid_r;
  logic [7:0]          byte_r;
  logic                adv;
  parse_state_t        st_r;
  parse_state_t        st_nxt;
  parse_result_t       res;
  logic                out_valid_r;
  logic [8:0]          number_r;
  logic [6:0]          level_r;

  assign adv      = in_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !in_valid_r || adv;

  mbsep_decode u_decode (
    .midi_byte (byte_r),
    .st        (st_r),
    .st_nxt    (st_nxt),
    .res       (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r    <= 1'b0;
      st_r.swallow  <= 1'b1;
      st_r.cmd      <= CMD_NONE;
      st_r.held     <= 1'b0;
      st_r.first    <= 7'd0;
      out_valid_r   <= 1'b0;
    end else begin
      if (in_ready) begin
        in_valid_r <= in_valid;
      end
      if (adv) begin
        st_r <= st_nxt;
      end
      if (adv) begin
        out_valid_r <= res.emit;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      byte_r <= in_midi_byte;
    end
    if (adv && res.emit) begin
      number_r <= res.number;
      level_r  <= res.level;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_event_number = number_r;
  assign out_event_level  = level_r;

  a_number_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (number_r[8:7] != 2'b11))
    else $error("event number out of range");

  a_stall_holds_word: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> in_valid_r)
    else $error("input stalled with empty input register");

  a_result_from_word: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(in_valid_r))
    else $error("result appeared without a parsed word");

  a_held_needs_cmd: assert property (@(posedge clk) disable iff (!rst_n)
    st_r.held |-> (st_r.cmd == CMD_NOTE_OFF || st_r.cmd == CMD_NOTE_ON ||
                   st_r.cmd == CMD_POLY_AT || st_r.cmd == CMD_CONTROL ||
                   st_r.cmd == CMD_BEND))
    else $error("first data word held under a command that takes none");

endmodule

>>> sv/mbsep_decode.sv
// mbsep_decode: combinational parse of one midi word against the running state
// depends on mbsep_pkg
module mbsep_decode (
  input  logic [7:0]              midi_byte,
  input  mbsep_pkg::parse_state_t st,
  output mbsep_pkg::parse_state_t st_nxt,
  output mbsep_pkg::parse_result_t res
);
  import mbsep_pkg::*;

  logic [6:0] data;

  assign data = midi_byte[6:0];

  always_comb begin
    st_nxt     = st;
    res.emit   = 1'b0;
    res.number = {EVT_NOTE_ON, st.first};
    res.level  = data;
    if (midi_byte[7]) begin
      if (midi_byte < BYTE_REALTIME_MIN) begin
        if (midi_byte >= BYTE_SYSTEM_MIN) begin
          st_nxt.swallow = (midi_byte <= BYTE_SWALLOW_MAX);
        end else begin
          st_nxt.swallow = 1'b0;
          st_nxt.cmd     = midi_byte[7:4];
          st_nxt.held    = 1'b0;
        end
      end
    end else if (!st.swallow) begin
      unique case (st.cmd) inside
        CMD_NOTE_OFF, CMD_NOTE_ON, CMD_POLY_AT, CMD_CONTROL: begin
          if (!st.held) begin
            st_nxt.first = data;
            st_nxt.held  = 1'b1;
          end else begin
            st_nxt.held = 1'b0;
            if (st.cmd == CMD_CONTROL) begin
              res.emit   = 1'b1;
              res.number = {EVT_CONTROL, st.first};
            end else if (st.cmd != CMD_POLY_AT) begin
              res.emit = 1'b1;
              if (st.cmd == CMD_NOTE_ON && data != 7'd0) begin
                res.number = {EVT_NOTE_ON, st.first};
              end else begin
                res.number = {EVT_NOTE_OFF, st.first};
              end
            end
          end
        end
        CMD_PROGRAM, CMD_CHAN_PRESS: begin
          st_nxt.held = 1'b0;
        end
        CMD_BEND: begin
          if (!st.held) begin
            st_nxt.first = data;
            st_nxt.held  = 1'b1;
          end else begin
            st_nxt.held = 1'b0;
          end
        end
        default: begin
        end
      endcase
    end
  end

endmodule

>>> test/tb_midi_byte_stream_event_parser_core.sv
// testbench for midi_byte_stream_event_parser_core: directed and random midi words,
// events predicted by a running status parser model in this file and checked in order
// depends on mbsep_pkg and the core rtl
`timescale 1ns / 100ps

module tb_midi_byte_stream_event_parser_core;
  import mbsep_pkg::*;

  localparam int CYCLE_LIMIT  = 200000;
  localparam int RANDOM_WORDS = 1000;
  localparam int IDLE_PCT     = 13;

  typedef struct {
    logic [8:0] number;
    logic [6:0] level;
  } midi_evt_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [7:0] in_midi_byte = 8'h00;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [8:0] out_event_number;
  logic [6:0] out_event_level;

  logic [7:0]   word_queue[$];
  midi_evt_t    expected_events[$];
  parse_state_t parser;
  int           words_accepted = 0;
  int           events_seen = 0;
  int           failures = 0;
  int           cycles = 0;
  logic         steady;

  midi_byte_stream_event_parser_core uut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_midi_byte(in_midi_byte),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_event_number(out_event_number),
    .out_event_level(out_event_level)
  );

  always #5 clk = ~clk;

  assign steady = (words_accepted >= 400) && (words_accepted < 600);

  task automatic push_event(input logic [1:0] kind, input logic [6:0] key,
                            input logic [6:0] level);
    midi_evt_t e;
    e.number = {kind, key};
    e.level  = level;
    expected_events.push_back(e);
  endtask

  task automatic parse_midi_word(input logic [7:0] b);
    logic [6:0] d;
    d = b[6:0];
    if (b[7]) begin
      if (b < BYTE_REALTIME_MIN) begin
        parser.swallow = 1'b0;
        if (b >= BYTE_SYSTEM_MIN) begin
          if (b <= BYTE_SWALLOW_MAX) parser.swallow = 1'b1;
        end else begin
          parser.cmd  = b[7:4];
          parser.held = 1'b0;
        end
      end
    end else if (!parser.swallow) begin
      case (parser.cmd)
        CMD_NOTE_OFF, CMD_NOTE_ON, CMD_POLY_AT, CMD_CONTROL, CMD_BEND: begin
          if (!parser.held) begin
            parser.first = d;
            parser.held  = 1'b1;
          end else begin
            parser.held = 1'b0;
            case (parser.cmd)
              CMD_CONTROL: push_event(EVT_CONTROL, parser.first, d);
              CMD_NOTE_ON: begin
                if (d != 7'd0) push_event(EVT_NOTE_ON, parser.first, d);
                else push_event(EVT_NOTE_OFF, parser.first, d);
              end
              CMD_NOTE_OFF: push_event(EVT_NOTE_OFF, parser.first, d);
              default: ;
            endcase
          end
        end
        CMD_PROGRAM, CMD_CHAN_PRESS: parser.held = 1'b0;
        default: ;
      endcase
    end
  endtask

  function automatic int add_word(input logic [7:0] b);
    word_queue.push_back(b);
    return (b >= BYTE_REALTIME_MIN) ? 0 : 1;
  endfunction

  function automatic int add_data(input logic [7:0] b);
    int n;
    n = 0;
    if ($urandom_range(0, 99) < 4) n += add_word(8'(BYTE_REALTIME_MIN + $urandom_range(0, 7)));
    n += add_word(b);
    return n;
  endfunction

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        parse_midi_word(in_midi_byte);
        words_accepted++;
      end
      if (!(in_valid && !in_ready)) begin
        if (word_queue.size() != 0 && (steady || $urandom_range(0, 99) >= IDLE_PCT)) begin
          in_midi_byte <= word_queue.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    midi_evt_t e;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        events_seen++;
        if (expected_events.size() == 0) begin
          $error("unexpected event number %0d level %0d", out_event_number, out_event_level);
          failures++;
        end else begin
          e = expected_events.pop_front();
          if (out_event_number !== e.number) begin
            $error("event_number expected %0d actual %0d", e.number, out_event_number);
            failures++;
          end
          if (out_event_level !== e.level) begin
            $error("event_level expected %0d actual %0d", e.level, out_event_level);
            failures++;
          end
        end
      end
      out_ready <= steady || ($urandom_range(0, 99) >= IDLE_PCT);
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  initial begin
    logic [7:0] directed[$];
    logic [3:0] cmd;
    int n, r, k, drain;
    parser = '{swallow: 1'b1, cmd: CMD_NONE, held: 1'b0, first: 7'd0};
    directed = '{8'hF8, 8'h05, 8'hFF, 8'hF6, 8'h12,
                 8'h90, 8'h3C, 8'h64, 8'h3C, 8'h00, 8'hF8, 8'h00, 8'h7F,
                 8'h8F, 8'h00, 8'h7F, 8'hBF, 8'h7F, 8'h00, 8'h07, 8'h7F,
                 8'hA0, 8'h10, 8'h20, 8'hC5, 8'h05, 8'hD0, 8'h40, 8'hE0, 8'h00, 8'h7F,
                 8'h90, 8'h20, 8'hF0, 8'h01, 8'hF7, 8'h30, 8'h31,
                 8'hF2, 8'h01, 8'h02, 8'hF5, 8'h40, 8'h41};
    foreach (directed[i]) n = add_word(directed[i]);

    n = 0;
    while (n < RANDOM_WORDS) begin
      r = $urandom_range(0, 99);
      if (r < 60) begin
        cmd = 4'($urandom_range(8, 14));
        if ($urandom_range(0, 99) < 70) n += add_word({cmd, 4'($urandom_range(0, 15))});
        else cmd = parser.cmd;
        n += add_data(8'($urandom_range(0, 127)));
        if (cmd != CMD_PROGRAM && cmd != CMD_CHAN_PRESS) begin
          if ($urandom_range(0, 99) < 20) n += add_data(8'h00);
          else n += add_data(8'($urandom_range(0, 127)));
        end
      end else if (r < 68) begin
        n += add_word(BYTE_SYSTEM_MIN);
        k = $urandom_range(0, 4);
        repeat (k) n += add_data(8'($urandom_range(0, 127)));
        n += add_word(8'hF7);
      end else if (r < 76) begin
        n += add_word(8'($urandom_range(241, 247)));
        k = $urandom_range(0, 2);
        repeat (k) n += add_data(8'($urandom_range(0, 127)));
      end else if (r < 83) begin
        n += add_word({4'($urandom_range(8, 14)), 4'($urandom_range(0, 15))});
        n += add_data(8'($urandom_range(0, 127)));
      end else if (r < 93) begin
        k = $urandom_range(2, 6);
        repeat (k) n += add_data(8'($urandom_range(0, 127)));
      end else begin
        n += add_word(8'($urandom_range(0, 255)));
      end
    end

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    while (word_queue.size() != 0 || in_valid) @(posedge clk);
    drain = 0;
    while (expected_events.size() != 0 && drain < 2000) begin
      @(posedge clk);
      drain++;
    end
    repeat (10) @(posedge clk);
    if (expected_events.size() != 0) begin
      $error("%0d expected events never arrived", expected_events.size());
      failures++;
    end

    $display("run covered %0d midi words with %0d events compared", words_accepted,
             events_seen);
    $display("failures counted: %0d", failures);
    if (failures == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
